FILE: src/nfpa_pkg.sv
// ----------------------------------------------------------------------------
// nfpa_pkg
// Shared types, field widths and codes of the next-fit page allocator.
// ----------------------------------------------------------------------------
package nfpa_pkg;

  // field widths of the channels
  localparam int CMD_W    = 2;
  localparam int REQ_W    = 24;
  localparam int PAGE_F_W = 12;
  localparam int STATUS_W = 2;
  localparam int HDR_W    = 7;
  localparam int MARK_W   = 2;

  // request plus header, and that sum plus the rounding term
  localparam int TOTAL_W  = 25;
  localparam int NUM_W    = 26;

  localparam logic [HDR_W-1:0] HDR_RESET = 7'd8;

  // defaults of the top level parameters
  localparam int DEF_PAGE_COUNT = 4096;
  localparam int DEF_PAGE_BYTES = 4096;

  // commands
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // result status
  localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FAIL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_HEAD = 2'd2;

  // page marks
  typedef logic [MARK_W-1:0] mark_t;
  localparam mark_t MARK_FREE = 2'd0;
  localparam mark_t MARK_HEAD = 2'd1;
  localparam mark_t MARK_TAIL = 2'd2;

  // sequencer states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_MARK,
    ST_FREE_RD,
    ST_FREE_HEAD,
    ST_FREE_TAIL,
    ST_CLEAR,
    ST_RESP
  } ctrl_state_t;

  // page count unit result
  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] pages;
  } div_rsp_t;

endpackage

FILE: src/nfpa_if.sv
// ----------------------------------------------------------------------------
// nfpa channel interfaces
// Valid/ready channels for commands, results and the header register.
// ----------------------------------------------------------------------------

// command channel
interface nfpa_req_if;
  logic                          valid;
  logic                          ready;
  logic [nfpa_pkg::CMD_W-1:0]    cmd;
  logic [nfpa_pkg::REQ_W-1:0]    request_bytes;
  logic [nfpa_pkg::PAGE_F_W-1:0] free_page;

  modport source (output valid, output cmd, output request_bytes, output free_page,
                  input ready);
  modport sink (input valid, input cmd, input request_bytes, input free_page,
                output ready);
endinterface

// result channel
interface nfpa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [nfpa_pkg::STATUS_W-1:0] status;
  logic [nfpa_pkg::PAGE_F_W-1:0] first_page;

  modport source (output valid, output status, output first_page, input ready);
  modport sink (input valid, input status, input first_page, output ready);
endinterface

// header register write channel
interface nfpa_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [nfpa_pkg::HDR_W-1:0] header_bytes;

  modport source (output valid, output header_bytes, input ready);
  modport sink (input valid, input header_bytes, output ready);
endinterface

FILE: src/next_fit_page_allocator_unit.sv
// ----------------------------------------------------------------------------
// next_fit_page_allocator_unit
// Next-fit contiguous page allocator over a page mark memory.
// ----------------------------------------------------------------------------
// Commands are taken one at a time; in_chan.ready is high only while the
// block is idle, and a finished result waits in the output register without
// blocking the next command. The single read port of the page mark memory
// yields one mark per cycle. Allocate first turns the byte total into a page
// count by a reciprocal multiplication, then scans from the search pointer,
// visiting up to PAGE_COUNT pages, and marks the pages of the run it finds.
// Free reads the given page and, if it is a head, releases it and each tail
// page after it; any other page is left as it is. Clear frees every page.
// After reset the block clears the map before it takes its first command;
// the header register can be written throughout.
module next_fit_page_allocator_unit #(
  parameter int PAGE_COUNT = nfpa_pkg::DEF_PAGE_COUNT,
  parameter int PAGE_BYTES = nfpa_pkg::DEF_PAGE_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  nfpa_req_if.sink   in_chan,
  nfpa_rsp_if.source out_chan,
  nfpa_cfg_if.sink   cfg_chan
);

  localparam int AW = $clog2(PAGE_COUNT);

  logic [nfpa_pkg::HDR_W-1:0]   hdr_r, hdr_nxt;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  nfpa_pkg::mark_t              mem_wdata;
  logic [AW-1:0]                mem_raddr;
  nfpa_pkg::mark_t              mem_rdata;
  logic                         div_start;
  logic [nfpa_pkg::TOTAL_W-1:0] div_total;
  nfpa_pkg::div_rsp_t           div_rsp;

  // header register, always ready for a transfer
  assign cfg_chan.ready = 1'b1;
  assign hdr_nxt        = cfg_chan.valid ? cfg_chan.header_bytes : hdr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r <= nfpa_pkg::HDR_RESET;
    end else begin
      hdr_r <= hdr_nxt;
    end
  end

  // page mark memory
  nfpa_map_mem #(
    .DEPTH (PAGE_COUNT),
    .AW    (AW)
  ) u_map_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // byte total to page count
  nfpa_page_div #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_page_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .total (div_total),
    .rsp   (div_rsp)
  );

  // sequencer
  nfpa_ctrl #(
    .PAGE_COUNT (PAGE_COUNT),
    .AW         (AW)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_chan.valid),
    .in_ready         (in_chan.ready),
    .in_cmd           (in_chan.cmd),
    .in_request_bytes (in_chan.request_bytes),
    .in_free_page     (in_chan.free_page),
    .header_bytes     (hdr_r),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_status       (out_chan.status),
    .out_first_page   (out_chan.first_page),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_raddr        (mem_raddr),
    .mem_rdata        (mem_rdata),
    .div_start        (div_start),
    .div_total        (div_total),
    .div_rsp          (div_rsp)
  );

endmodule

FILE: src/nfpa_map_mem.sv
// ----------------------------------------------------------------------------
// nfpa_map_mem
// Page mark memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nfpa_map_mem #(
  parameter int DEPTH = nfpa_pkg::DEF_PAGE_COUNT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  nfpa_pkg::mark_t     wdata,
  input  logic [AW-1:0]       raddr,
  output nfpa_pkg::mark_t     rdata
);

  nfpa_pkg::mark_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/nfpa_page_div.sv
// ----------------------------------------------------------------------------
// nfpa_page_div
// Turns a byte total into a page count, rounding up, by multiplying with the
// reciprocal of the page size; registers the rounded total, then the quotient.
// ----------------------------------------------------------------------------
module nfpa_page_div #(
  parameter int PAGE_BYTES = nfpa_pkg::DEF_PAGE_BYTES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [nfpa_pkg::TOTAL_W-1:0]   total,
  output nfpa_pkg::div_rsp_t             rsp
);

  localparam int NUM_W = nfpa_pkg::NUM_W;
  localparam int SHIFT = $clog2(PAGE_BYTES);
  // scaled reciprocal, exact for every numerator of NUM_W bits
  localparam logic [63:0]      SCALE      = 64'd1 << (NUM_W + SHIFT);
  localparam logic [63:0]      RECIP_FULL = (SCALE + 64'(PAGE_BYTES) - 64'd1) /
                                            64'(PAGE_BYTES);
  localparam logic [NUM_W:0]   RECIP      = (NUM_W + 1)'(RECIP_FULL);
  localparam logic [NUM_W-1:0] ROUND_UP   = NUM_W'(PAGE_BYTES - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [2*NUM_W:0] prod;

  // load the rounded total, then take the high bits of the product
  always_comb begin
    prod     = num_r * RECIP;
    busy_nxt = start;
    done_nxt = busy_r;
    num_nxt  = start ? NUM_W'(total) + ROUND_UP : num_r;
    quo_nxt  = busy_r ? NUM_W'(prod[2*NUM_W:NUM_W+SHIFT]) : quo_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.pages = quo_r;

endmodule

FILE: src/nfpa_ctrl.sv
// ----------------------------------------------------------------------------
// nfpa_ctrl
// Sequencer: scans, marks and frees pages in the mark memory, clears it, and
// holds the result register.
// ----------------------------------------------------------------------------
module nfpa_ctrl #(
  parameter int PAGE_COUNT = nfpa_pkg::DEF_PAGE_COUNT,
  parameter int AW         = $clog2(PAGE_COUNT)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // command transfer
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [nfpa_pkg::CMD_W-1:0]      in_cmd,
  input  logic [nfpa_pkg::REQ_W-1:0]      in_request_bytes,
  input  logic [nfpa_pkg::PAGE_F_W-1:0]   in_free_page,
  input  logic [nfpa_pkg::HDR_W-1:0]      header_bytes,
  // result transfer
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [nfpa_pkg::STATUS_W-1:0]   out_status,
  output logic [nfpa_pkg::PAGE_F_W-1:0]   out_first_page,
  // mark memory
  output logic                            mem_we,
  output logic [AW-1:0]                   mem_waddr,
  output nfpa_pkg::mark_t                 mem_wdata,
  output logic [AW-1:0]                   mem_raddr,
  input  nfpa_pkg::mark_t                 mem_rdata,
  // page count unit
  output logic                            div_start,
  output logic [nfpa_pkg::TOTAL_W-1:0]    div_total,
  input  nfpa_pkg::div_rsp_t              div_rsp
);

  localparam int CNT_W = $clog2(PAGE_COUNT + 1);
  localparam logic [AW-1:0]    LAST_IDX = AW'(PAGE_COUNT - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PAGE_COUNT);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAGE_COUNT - 1);

  nfpa_pkg::ctrl_state_t state_r, state_nxt;

  logic [AW-1:0]                  ptr_r, ptr_nxt;
  logic [AW-1:0]                  search_r, search_nxt;
  logic [AW-1:0]                  issue_idx_r, issue_idx_nxt;
  logic [CNT_W-1:0]               issue_cnt_r, issue_cnt_nxt;
  logic                           b_valid_r, b_valid_nxt;
  logic                           b_last_r, b_last_nxt;
  logic [AW-1:0]                  b_idx_r, b_idx_nxt;
  logic [CNT_W-1:0]               run_cnt_r, run_cnt_nxt;
  logic [AW-1:0]                  run_start_r, run_start_nxt;
  logic [CNT_W-1:0]               pages_r, pages_nxt;
  logic [CNT_W-1:0]               mark_cnt_r, mark_cnt_nxt;
  logic [nfpa_pkg::STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic [nfpa_pkg::PAGE_F_W-1:0]  res_start_r, res_start_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [nfpa_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [nfpa_pkg::PAGE_F_W-1:0]  out_start_r, out_start_nxt;

  logic                           accept;
  logic                           free_in_range;
  logic                           pages_bad;
  logic                           out_free;
  logic [CNT_W-1:0]               run_cnt_eff;
  logic [CNT_W-1:0]               run_cnt_inc;
  logic [AW-1:0]                  run_base;
  logic                           scan_found;
  logic                           scan_fail;
  logic [CNT_W:0]                 run_end;
  logic                           ptr_at_last;

  // shared decode
  always_comb begin
    accept        = (state_r == nfpa_pkg::ST_IDLE) && in_valid;
    free_in_range = (32'(in_free_page) < 32'(PAGE_COUNT));
    pages_bad     = (div_rsp.pages == '0) ||
                    (div_rsp.pages > nfpa_pkg::NUM_W'(PAGE_COUNT));
    out_free      = !out_valid_r || out_ready;
    ptr_at_last   = (ptr_r == LAST_IDX);
    // run counting on the mark that arrives from memory; a run restarts at page 0
    run_cnt_eff   = (b_idx_r == '0) ? '0 : run_cnt_r;
    run_cnt_inc   = run_cnt_eff + 1'b1;
    run_base      = (run_cnt_eff == '0) ? b_idx_r : run_start_r;
    scan_found    = b_valid_r && (mem_rdata == nfpa_pkg::MARK_FREE) &&
                    (run_cnt_inc == pages_r);
    scan_fail     = b_valid_r && b_last_r && !scan_found;
    run_end       = (CNT_W + 1)'(run_base) + (CNT_W + 1)'(pages_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nfpa_pkg::ST_INIT: begin
        if (ptr_at_last) state_nxt = nfpa_pkg::ST_IDLE;
      end
      nfpa_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            nfpa_pkg::CMD_ALLOC: state_nxt = nfpa_pkg::ST_DIV;
            nfpa_pkg::CMD_FREE:
              state_nxt = free_in_range ? nfpa_pkg::ST_FREE_RD : nfpa_pkg::ST_RESP;
            nfpa_pkg::CMD_CLEAR: state_nxt = nfpa_pkg::ST_CLEAR;
            default:             state_nxt = nfpa_pkg::ST_RESP;
          endcase
        end
      end
      nfpa_pkg::ST_DIV: begin
        if (div_rsp.done) state_nxt = pages_bad ? nfpa_pkg::ST_RESP : nfpa_pkg::ST_SCAN;
      end
      nfpa_pkg::ST_SCAN: begin
        if (scan_found) begin
          state_nxt = nfpa_pkg::ST_MARK;
        end else if (scan_fail) begin
          state_nxt = nfpa_pkg::ST_RESP;
        end
      end
      nfpa_pkg::ST_MARK: begin
        if (mark_cnt_r == pages_r - 1'b1) state_nxt = nfpa_pkg::ST_RESP;
      end
      nfpa_pkg::ST_FREE_RD: state_nxt = nfpa_pkg::ST_FREE_HEAD;
      nfpa_pkg::ST_FREE_HEAD: begin
        if (mem_rdata != nfpa_pkg::MARK_HEAD || ptr_at_last) begin
          state_nxt = nfpa_pkg::ST_RESP;
        end else begin
          state_nxt = nfpa_pkg::ST_FREE_TAIL;
        end
      end
      nfpa_pkg::ST_FREE_TAIL: begin
        if (mem_rdata != nfpa_pkg::MARK_TAIL || ptr_at_last) state_nxt = nfpa_pkg::ST_RESP;
      end
      nfpa_pkg::ST_CLEAR: begin
        if (ptr_at_last) state_nxt = nfpa_pkg::ST_RESP;
      end
      nfpa_pkg::ST_RESP: begin
        if (out_free) state_nxt = nfpa_pkg::ST_IDLE;
      end
      default: state_nxt = nfpa_pkg::ST_INIT;
    endcase
  end

  // memory, page count unit and handshake outputs
  always_comb begin
    in_ready  = (state_r == nfpa_pkg::ST_IDLE);
    div_start = accept && (in_cmd == nfpa_pkg::CMD_ALLOC);
    div_total = nfpa_pkg::TOTAL_W'(in_request_bytes) + nfpa_pkg::TOTAL_W'(header_bytes);
    mem_we    = 1'b0;
    mem_waddr = ptr_r;
    mem_wdata = nfpa_pkg::MARK_FREE;
    mem_raddr = ptr_r;
    case (state_r)
      nfpa_pkg::ST_INIT, nfpa_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
      end
      nfpa_pkg::ST_SCAN: begin
        mem_raddr = issue_idx_r;
      end
      nfpa_pkg::ST_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = (mark_cnt_r == '0) ? nfpa_pkg::MARK_HEAD : nfpa_pkg::MARK_TAIL;
      end
      nfpa_pkg::ST_FREE_HEAD: begin
        mem_we    = (mem_rdata == nfpa_pkg::MARK_HEAD);
        mem_raddr = ptr_r + 1'b1;
      end
      nfpa_pkg::ST_FREE_TAIL: begin
        mem_we    = (mem_rdata == nfpa_pkg::MARK_TAIL);
        mem_raddr = ptr_r + 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    ptr_nxt        = ptr_r;
    search_nxt     = search_r;
    issue_idx_nxt  = issue_idx_r;
    issue_cnt_nxt  = issue_cnt_r;
    b_valid_nxt    = 1'b0;
    b_last_nxt     = b_last_r;
    b_idx_nxt      = b_idx_r;
    run_cnt_nxt    = run_cnt_r;
    run_start_nxt  = run_start_r;
    pages_nxt      = pages_r;
    mark_cnt_nxt   = mark_cnt_r;
    res_status_nxt = res_status_r;
    res_start_nxt  = res_start_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    case (state_r)
      nfpa_pkg::ST_INIT: begin
        ptr_nxt = ptr_r + 1'b1;
      end
      nfpa_pkg::ST_IDLE: begin
        if (accept) begin
          res_status_nxt = nfpa_pkg::STATUS_DONE;
          res_start_nxt  = '0;
          ptr_nxt        = '0;
          if (in_cmd == nfpa_pkg::CMD_FREE) begin
            ptr_nxt = AW'(in_free_page);
            if (!free_in_range) res_status_nxt = nfpa_pkg::STATUS_NOT_HEAD;
          end
        end
      end
      nfpa_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          if (pages_bad) res_status_nxt = nfpa_pkg::STATUS_FAIL;
          pages_nxt     = CNT_W'(div_rsp.pages);
          issue_idx_nxt = search_r;
          issue_cnt_nxt = '0;
          run_cnt_nxt   = '0;
        end
      end
      nfpa_pkg::ST_SCAN: begin
        // issue one read a cycle until every page has been visited
        if (issue_cnt_r != CNT_FULL) begin
          b_valid_nxt   = 1'b1;
          b_idx_nxt     = issue_idx_r;
          b_last_nxt    = (issue_cnt_r == CNT_LAST);
          issue_idx_nxt = (issue_idx_r == LAST_IDX) ? '0 : issue_idx_r + 1'b1;
          issue_cnt_nxt = issue_cnt_r + 1'b1;
        end
        // evaluate the mark returned for the previous read
        if (b_valid_r) begin
          if (mem_rdata == nfpa_pkg::MARK_FREE) begin
            run_cnt_nxt   = run_cnt_inc;
            run_start_nxt = run_base;
          end else begin
            run_cnt_nxt = '0;
          end
        end
        if (scan_found) begin
          b_valid_nxt   = 1'b0;
          ptr_nxt       = run_base;
          mark_cnt_nxt  = '0;
          res_start_nxt = nfpa_pkg::PAGE_F_W'(run_base);
          search_nxt    = (run_end == (CNT_W + 1)'(PAGE_COUNT)) ? '0 : AW'(run_end);
        end else if (scan_fail) begin
          b_valid_nxt    = 1'b0;
          res_status_nxt = nfpa_pkg::STATUS_FAIL;
        end
      end
      nfpa_pkg::ST_MARK: begin
        ptr_nxt      = ptr_r + 1'b1;
        mark_cnt_nxt = mark_cnt_r + 1'b1;
      end
      nfpa_pkg::ST_FREE_HEAD: begin
        if (mem_rdata != nfpa_pkg::MARK_HEAD) begin
          res_status_nxt = nfpa_pkg::STATUS_NOT_HEAD;
        end else if (!ptr_at_last) begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      nfpa_pkg::ST_FREE_TAIL: begin
        if (mem_rdata == nfpa_pkg::MARK_TAIL && !ptr_at_last) ptr_nxt = ptr_r + 1'b1;
      end
      nfpa_pkg::ST_CLEAR: begin
        ptr_nxt    = ptr_r + 1'b1;
        search_nxt = '0;
      end
      nfpa_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_start_nxt  = res_start_r;
        end
      end
      default: begin
        ptr_nxt = ptr_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nfpa_pkg::ST_INIT;
      ptr_r       <= '0;
      search_r    <= '0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      search_r    <= search_nxt;
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    issue_idx_r  <= issue_idx_nxt;
    issue_cnt_r  <= issue_cnt_nxt;
    b_last_r     <= b_last_nxt;
    b_idx_r      <= b_idx_nxt;
    run_cnt_r    <= run_cnt_nxt;
    run_start_r  <= run_start_nxt;
    pages_r      <= pages_nxt;
    mark_cnt_r   <= mark_cnt_nxt;
    res_status_r <= res_status_nxt;
    res_start_r  <= res_start_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_first_page = out_start_r;

endmodule

FILE: src/nfpa_checker.sv
// ----------------------------------------------------------------------------
// nfpa_checker
// Port-level checks of the page allocator, bound to the top level.
// ----------------------------------------------------------------------------
module nfpa_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [nfpa_pkg::STATUS_W-1:0] out_status,
  input logic [nfpa_pkg::PAGE_F_W-1:0] out_first_page
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pend_r, pend_nxt;

  // commands taken whose result has not yet been transferred
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_xfer && !out_xfer) begin
      pend_nxt = pend_r + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_first_page))
    else $error("result changed while stalled");

  // one command at a time
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("command taken while another is in progress");

  // no result without a command behind it
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without a pending command");

  // failed allocation and ignored free report first page zero
  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != nfpa_pkg::STATUS_DONE |-> out_first_page == '0)
    else $error("first page not zero on a failed command");

endmodule

bind next_fit_page_allocator_unit nfpa_checker u_nfpa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_status     (out_chan.status),
  .out_first_page (out_chan.first_page)
);

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the next-fit page allocator. Commands go out from a backlog
// in random bursts, each transfer is applied to a shadow page map in the
// testbench, and every result transfer is checked field by field against the
// oldest predicted result. The header register is rewritten between phases
// while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import nfpa_pkg::*;

  localparam int PAGES       = DEF_PAGE_COUNT;
  localparam int PG_BYTES    = DEF_PAGE_BYTES;
  localparam int CYCLE_LIMIT = 6000000;
  localparam int HOLD_CYCLES = 500;

  // command value with no meaning in the block
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // receiver stall patterns
  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [REQ_W-1:0]    request_bytes;
    logic [PAGE_F_W-1:0] free_page;
  } page_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAGE_F_W-1:0] first_page;
  } page_result_t;

  logic clk;
  logic rst_n;

  nfpa_req_if cmd_if ();
  nfpa_rsp_if res_if ();
  nfpa_cfg_if hdr_if ();

  next_fit_page_allocator_unit #(
    .PAGE_COUNT(PAGES),
    .PAGE_BYTES(PG_BYTES)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (cmd_if),
    .out_chan(res_if),
    .cfg_chan(hdr_if)
  );

  // shadow state of the allocator
  mark_t               map_model [PAGES];
  logic [PAGE_F_W-1:0] next_search;
  logic [HDR_W-1:0]    hdr_model;

  page_cmd_t    cmd_backlog[$];
  page_result_t page_results_due[$];
  page_cmd_t    cmd_on_bus;

  int cmds_queued;
  int cmds_accepted;
  int results_seen;
  int errors;
  int cycle_count;

  // sender burst state
  int burst_left;
  int gap_left;

  // receiver stall state
  int       hold_left;
  bit       hold_done;
  int       pat_left;
  rx_mode_t pat_mode;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void clear_model();
    for (int i = 0; i < PAGES; i++) map_model[i] = MARK_FREE;
    next_search = '0;
  endfunction

  // apply one command to the shadow map and return its result
  function automatic page_result_t apply_page_cmd(input page_cmd_t c);
    page_result_t r;
    int unsigned  total;
    int unsigned  pages;
    int unsigned  idx;
    int unsigned  run_len;
    int unsigned  run_start;
    int unsigned  k;
    bit           found;
    r.status     = STATUS_DONE;
    r.first_page = '0;
    found        = 1'b0;
    run_start    = 0;
    case (c.cmd)
      CMD_ALLOC: begin
        total = c.request_bytes + hdr_model;
        pages = (total + PG_BYTES - 1) / PG_BYTES;
        if (pages != 0 && pages <= PAGES) begin
          idx     = next_search;
          run_len = 0;
          for (k = 0; k < PAGES && !found; k++) begin
            // a run never wraps from the last page to page 0
            if (idx == 0) run_len = 0;
            if (map_model[idx] == MARK_FREE) begin
              if (run_len == 0) run_start = idx;
              run_len++;
              if (run_len == pages) found = 1'b1;
            end else begin
              run_len = 0;
            end
            idx = (idx + 1) % PAGES;
          end
        end
        if (found) begin
          for (k = 0; k < pages; k++)
            map_model[run_start + k] = (k == 0) ? MARK_HEAD : MARK_TAIL;
          next_search  = (run_start + pages) % PAGES;
          r.first_page = run_start[PAGE_F_W-1:0];
        end else begin
          r.status = STATUS_FAIL;
        end
      end
      CMD_FREE: begin
        if (map_model[c.free_page] != MARK_HEAD) begin
          r.status = STATUS_NOT_HEAD;
        end else begin
          map_model[c.free_page] = MARK_FREE;
          for (k = c.free_page + 1; k < PAGES && map_model[k] == MARK_TAIL; k++)
            map_model[k] = MARK_FREE;
        end
      end
      CMD_CLEAR: clear_model();
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic add_cmd(input logic [CMD_W-1:0] cmd, input int unsigned req,
                         input int unsigned page);
    page_cmd_t c;
    c.cmd           = cmd;
    c.request_bytes = req[REQ_W-1:0];
    c.free_page     = page[PAGE_F_W-1:0];
    cmd_backlog.push_back(c);
    cmds_queued++;
  endtask

  // a live head page from the shadow map, or any page when there is none
  function automatic int unsigned pick_head();
    int unsigned heads[$];
    for (int i = 0; i < PAGES; i++)
      if (map_model[i] == MARK_HEAD) heads.push_back(i);
    if (heads.size() == 0) return $urandom_range(0, PAGES - 1);
    return heads[$urandom_range(0, heads.size() - 1)];
  endfunction

  // request sizes: mostly a few pages, some exact page boundaries, rarely huge
  function automatic int unsigned pick_request();
    int unsigned sel;
    int unsigned k;
    sel = $urandom_range(0, 99);
    k   = $urandom_range(1, 8);
    if (sel < 60) return $urandom_range(0, 4 * PG_BYTES - 1);
    if (sel < 88) return $urandom_range(0, 64 * PG_BYTES);
    if (sel < 95) return k * PG_BYTES - hdr_model + $urandom_range(0, 1);
    return $urandom & 24'hFFFFFF;
  endfunction

  task automatic add_random_cmd();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55)      add_cmd(CMD_ALLOC, pick_request(), $urandom);
    else if (sel < 85) add_cmd(CMD_FREE, $urandom, pick_head());
    else if (sel < 92) add_cmd(CMD_FREE, $urandom, $urandom);
    else if (sel < 96) add_cmd(CMD_UNUSED, $urandom, $urandom);
    else               add_cmd(CMD_CLEAR, $urandom, $urandom);
  endtask

  // random commands in small batches so that frees mostly hit live heads
  task automatic run_random(input int n);
    int chunk;
    while (n > 0) begin
      chunk = $urandom_range(4, 12);
      if (chunk > n) chunk = n;
      repeat (chunk) add_random_cmd();
      n -= chunk;
      do @(posedge clk); while (cmd_backlog.size() != 0);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (cmds_accepted != cmds_queued || page_results_due.size() != 0);
  endtask

  task automatic write_header(input logic [HDR_W-1:0] value);
    hdr_if.valid        <= 1'b1;
    hdr_if.header_bytes <= value;
    do @(posedge clk); while (!hdr_if.ready);
    hdr_model     = value;
    hdr_if.valid <= 1'b0;
  endtask

  // command driver: bursts of random length separated by random gaps
  always @(posedge clk) begin
    logic nxt_valid;
    if (!rst_n) begin
      cmd_if.valid <= 1'b0;
    end else begin
      nxt_valid = cmd_if.valid;
      if (cmd_if.valid && cmd_if.ready) begin
        page_results_due.push_back(apply_page_cmd(cmd_on_bus));
        cmds_accepted++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_backlog.size() != 0) begin
          cmd_on_bus            = cmd_backlog.pop_front();
          cmd_if.cmd           <= cmd_on_bus.cmd;
          cmd_if.request_bytes <= cmd_on_bus.request_bytes;
          cmd_if.free_page     <= cmd_on_bus.free_page;
          nxt_valid             = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 8);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      cmd_if.valid <= nxt_valid;
    end
  end

  // result receiver: stall patterns plus one long hold-off while at least three commands wait
  always @(posedge clk) begin
    logic nxt_ready;
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (!hold_done && results_seen >= 50 && cmd_backlog.size() >= 3) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
        nxt_ready = 1'b0;
      end else begin
        if (pat_left <= 0) begin
          pat_left = $urandom_range(8, 40);
          pat_mode = rx_mode_t'($urandom_range(0, 3));
        end
        pat_left--;
        case (pat_mode)
          RX_OPEN:     nxt_ready = 1'b1;
          RX_RANDOM:   nxt_ready = $urandom_range(0, 1);
          RX_SPARSE:   nxt_ready = ($urandom_range(0, 3) == 0);
          RX_PERIODIC: nxt_ready = (pat_left % 3 != 0);
          default:     nxt_ready = 1'b1;
        endcase
      end
      res_if.ready <= nxt_ready;
    end
  end

  // result monitor: compare each transfer with the oldest prediction
  always @(posedge clk) begin
    page_result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      results_seen++;
      if (page_results_due.size() == 0) begin
        report_mismatch("result with nothing predicted, status", res_if.status, 0);
      end else begin
        want = page_results_due.pop_front();
        if (res_if.status !== want.status)
          report_mismatch("status", res_if.status, want.status);
        if (res_if.first_page !== want.first_page)
          report_mismatch("first_page", res_if.first_page, want.first_page);
      end
    end
  end

  // run time limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    rst_n                = 1'b0;
    cmd_if.valid         = 1'b0;
    cmd_if.cmd           = CMD_ALLOC;
    cmd_if.request_bytes = '0;
    cmd_if.free_page     = '0;
    res_if.ready         = 1'b0;
    hdr_if.valid         = 1'b0;
    hdr_if.header_bytes  = HDR_RESET;
    hdr_model            = HDR_RESET;
    clear_model();
    cmds_queued   = 0;
    cmds_accepted = 0;
    results_seen  = 0;
    errors        = 0;
    cycle_count   = 0;
    burst_left    = 1;
    gap_left      = 0;
    hold_left     = 0;
    hold_done     = 1'b0;
    pat_left      = 0;
    pat_mode      = RX_OPEN;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed, header at its reset value
    add_cmd(CMD_ALLOC, 0, 0);
    add_cmd(CMD_ALLOC, PG_BYTES - 8, 0);
    add_cmd(CMD_ALLOC, PG_BYTES - 7, 0);
    add_cmd(CMD_FREE, 0, 1);
    // second free of the same page, a tail page and a never used page
    add_cmd(CMD_FREE, 0, 1);
    add_cmd(CMD_FREE, 0, 3);
    add_cmd(CMD_FREE, 24'hFFFFFF, 12'hFFF);
    add_cmd(CMD_UNUSED, 24'hFFFFFF, 12'hFFF);
    // oversized request, then the whole map in one run
    add_cmd(CMD_ALLOC, 24'hFFFFFF, 0);
    add_cmd(CMD_CLEAR, 0, 0);
    add_cmd(CMD_ALLOC, PAGES * PG_BYTES - 8, 0);
    add_cmd(CMD_ALLOC, 0, 0);
    add_cmd(CMD_FREE, 0, 0);
    // pointer left on the last page: a run may not wrap to page 0
    add_cmd(CMD_ALLOC, (PAGES - 1) * PG_BYTES - 8, 0);
    add_cmd(CMD_ALLOC, PG_BYTES - 7, 0);
    add_cmd(CMD_FREE, 0, 0);
    add_cmd(CMD_ALLOC, PG_BYTES - 7, 0);
    add_cmd(CMD_ALLOC, PAGES * PG_BYTES - 7, 0);
    add_cmd(CMD_CLEAR, 0, 0);
    wait_idle();
    run_random(30);
    wait_idle();

    // no header: a zero byte request gives no pages
    write_header(7'd0);
    add_cmd(CMD_ALLOC, 0, 0);
    add_cmd(CMD_ALLOC, 1, 0);
    add_cmd(CMD_ALLOC, PG_BYTES, 0);
    add_cmd(CMD_ALLOC, PG_BYTES + 1, 0);
    wait_idle();
    run_random(30);
    wait_idle();

    // largest header the register holds
    write_header(7'd127);
    run_random(30);
    wait_idle();

    write_header(7'd64);
    run_random(30);
    wait_idle();

    repeat (100) @(posedge clk);
    if (page_results_due.size() != 0)
      report_mismatch("results never delivered", 0, page_results_due.size());
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: files.f
src/nfpa_pkg.sv
src/nfpa_if.sv
src/nfpa_map_mem.sv
src/nfpa_page_div.sv
src/nfpa_ctrl.sv
src/next_fit_page_allocator_unit.sv
src/nfpa_checker.sv
sim/tb.sv
